/* rtl/taas_pkg.sv */
// taas_pkg: shared constants and the CORDIC angle table for the aim angle solver.
// No dependencies.
package taas_pkg;

  localparam int WORD_W = 64;
  localparam int ANG_W = 32;
  localparam int GUARD_BITS = 24;
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;
  localparam logic signed [ANG_W-1:0] DEG180 = 32'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360 = 32'sd23592960;

  localparam logic [7:0] REG_DRAG_GAIN = 8'd0;
  localparam logic [7:0] REG_PITCH_LIMIT = 8'd1;

  localparam logic [15:0] DRAG_GAIN_RST = 16'd1311;
  localparam logic [22:0] PITCH_LIMIT_RST = 23'd5242880;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  function automatic ang_t atan_q16(input int idx);
    ang_t v;
    case (idx)
      0: v = 32'sd2949120;
      1: v = 32'sd1740967;
      2: v = 32'sd919879;
      3: v = 32'sd466945;
      4: v = 32'sd234379;
      5: v = 32'sd117304;
      6: v = 32'sd58666;
      7: v = 32'sd29335;
      8: v = 32'sd14668;
      9: v = 32'sd7334;
      10: v = 32'sd3667;
      11: v = 32'sd1833;
      12: v = 32'sd917;
      13: v = 32'sd458;
      14: v = 32'sd229;
      15: v = 32'sd115;
      16: v = 32'sd57;
      17: v = 32'sd29;
      18: v = 32'sd14;
      19: v = 32'sd7;
      20: v = 32'sd4;
      21: v = 32'sd2;
      22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/taas_cordic.sv */
// taas_cordic: pipelined vectoring CORDIC, one register stage per iteration.
// Depends on taas_pkg.
module taas_cordic #(
  parameter int STAGES = 20,
  parameter int SB_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  taas_pkg::word_t        in_x,
  input  taas_pkg::word_t        in_y,
  input  taas_pkg::ang_t         in_ang,
  input  logic [SB_W-1:0]        in_sb,
  output logic                   out_vld,
  output taas_pkg::word_t        out_x,
  output taas_pkg::ang_t         out_ang,
  output logic [SB_W-1:0]        out_sb
);

  logic            vld_r [STAGES];
  taas_pkg::word_t x_r   [STAGES];
  taas_pkg::word_t y_r   [STAGES];
  taas_pkg::ang_t  ang_r [STAGES];
  logic [SB_W-1:0] sb_r  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic            vld_i;
    taas_pkg::word_t x_i;
    taas_pkg::word_t y_i;
    taas_pkg::ang_t  ang_i;
    logic [SB_W-1:0] sb_i;
    taas_pkg::word_t x_nxt;
    taas_pkg::word_t y_nxt;
    taas_pkg::ang_t  ang_nxt;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign x_i = in_x;
      assign y_i = in_y;
      assign ang_i = in_ang;
      assign sb_i = in_sb;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign x_i = x_r[k-1];
      assign y_i = y_r[k-1];
      assign ang_i = ang_r[k-1];
      assign sb_i = sb_r[k-1];
    end

    always_comb begin
      if (!y_i[taas_pkg::WORD_W-1]) begin
        x_nxt = x_i + (y_i >>> k);
        y_nxt = y_i - (x_i >>> k);
        ang_nxt = ang_i + taas_pkg::atan_q16(k);
      end else begin
        x_nxt = x_i - (y_i >>> k);
        y_nxt = y_i + (x_i >>> k);
        ang_nxt = ang_i - taas_pkg::atan_q16(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
      x_r[k] <= x_nxt;
      y_r[k] <= y_nxt;
      ang_r[k] <= ang_nxt;
      sb_r[k] <= sb_i;
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_x = x_r[STAGES-1];
  assign out_ang = ang_r[STAGES-1];
  assign out_sb = sb_r[STAGES-1];

endmodule

/* rtl/taas_mag_scale.sv */
// taas_mag_scale: removes the CORDIC gain from a magnitude in two stages: 32x32 products, then their sum.
// Depends on taas_pkg.
module taas_mag_scale #(
  parameter int SB_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  taas_pkg::word_t        in_x,
  input  logic [SB_W-1:0]        in_sb,
  output logic                   out_vld,
  output logic [taas_pkg::WORD_W-1:0] out_mag,
  output logic [SB_W-1:0]        out_sb
);

  logic [taas_pkg::WORD_W-1:0] mag_in;
  logic [63:0] p_hi_r, p_lo_r;
  logic [63:0] p_hi_nxt, p_lo_nxt;
  logic        vld_a_r, vld_b_r;
  logic [SB_W-1:0] sb_a_r, sb_b_r;
  logic [63:0] mag_r;

  always_comb begin
    mag_in = in_x[taas_pkg::WORD_W-1] ? '0 : in_x;
    p_hi_nxt = 64'(mag_in[63:32]) * 64'(taas_pkg::INV_GAIN_Q32);
    p_lo_nxt = 64'(mag_in[31:0]) * 64'(taas_pkg::INV_GAIN_Q32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
    p_hi_r <= p_hi_nxt;
    p_lo_r <= p_lo_nxt;
    sb_a_r <= in_sb;
    mag_r <= p_hi_r + {32'd0, p_lo_r[63:32]};
    sb_b_r <= sb_a_r;
  end

  assign out_vld = vld_b_r;
  assign out_mag = mag_r;
  assign out_sb = sb_b_r;

endmodule

/* rtl/target_aim_angle_solver_top.sv */
// target_aim_angle_solver_top: yaw/pitch aim angles from a target position.
// One word accepted every cycle, busy stays low.
// The two CORDIC pipelines have one register stage per iteration.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
// Depends on taas_pkg, taas_cordic, taas_mag_scale.
module target_aim_angle_solver_top #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  output logic signed [24:0] out_yaw_deg,
  output logic signed [23:0] out_pitch_deg,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [15:0] drag_gain_r;
  logic [22:0] pitch_limit_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_gain_r <= taas_pkg::DRAG_GAIN_RST;
      pitch_limit_r <= taas_pkg::PITCH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        taas_pkg::REG_DRAG_GAIN: drag_gain_r <= cfg_data[15:0];
        taas_pkg::REG_PITCH_LIMIT: pitch_limit_r <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // front stage: scale and pre-rotate
  logic            s0_vld_r;
  taas_pkg::word_t s0_x_r, s0_y_r, s0_z_r;
  taas_pkg::ang_t  s0_ang_r;
  logic            s0_zero_r;
  taas_pkg::word_t xs, ys;

  assign xs = {{8{in_pos_x[31]}}, in_pos_x, 24'd0};
  assign ys = {{8{in_pos_y[31]}}, in_pos_y, 24'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
    if (in_pos_x[31]) begin
      s0_x_r <= -xs;
      s0_y_r <= -ys;
      s0_ang_r <= in_pos_y[31] ? -taas_pkg::DEG180 : taas_pkg::DEG180;
    end else begin
      s0_x_r <= xs;
      s0_y_r <= ys;
      s0_ang_r <= '0;
    end
    s0_z_r <= {{8{in_pos_z[31]}}, in_pos_z, 24'd0};
    s0_zero_r <= (in_pos_x == 32'sd0) && (in_pos_y == 32'sd0);
  end

  // plane CORDIC
  localparam int SB1_W = taas_pkg::WORD_W + 1;
  logic             c1_vld;
  taas_pkg::word_t  c1_x;
  taas_pkg::ang_t   c1_ang;
  logic [SB1_W-1:0] c1_sb;

  taas_cordic #(.STAGES(CORDIC_STAGES), .SB_W(SB1_W)) u_cordic_plane (
    .clk(clk), .rst_n(rst_n),
    .in_vld(s0_vld_r), .in_x(s0_x_r), .in_y(s0_y_r), .in_ang(s0_ang_r),
    .in_sb({s0_z_r, s0_zero_r}),
    .out_vld(c1_vld), .out_x(c1_x), .out_ang(c1_ang), .out_sb(c1_sb)
  );

  taas_pkg::ang_t yaw_w;
  logic signed [24:0] yaw_c;

  always_comb begin
    yaw_w = c1_ang;
    if (yaw_w > taas_pkg::DEG180) yaw_w = yaw_w - taas_pkg::DEG360;
    if (yaw_w < -taas_pkg::DEG180) yaw_w = yaw_w + taas_pkg::DEG360;
    yaw_c = c1_sb[0] ? 25'sd0 : yaw_w[24:0];
  end

  localparam int SB2_W = taas_pkg::WORD_W + 25;
  logic             m1_vld;
  logic [63:0]      m1_mag;
  logic [SB2_W-1:0] m1_sb;

  taas_mag_scale #(.SB_W(SB2_W)) u_scale_plane (
    .clk(clk), .rst_n(rst_n),
    .in_vld(c1_vld), .in_x(c1_x), .in_sb({c1_sb[SB1_W-1:1], yaw_c}),
    .out_vld(m1_vld), .out_mag(m1_mag), .out_sb(m1_sb)
  );

  // elevation CORDIC
  taas_pkg::word_t m1_z;
  logic            zero2;
  assign m1_z = m1_sb[SB2_W-1:25];
  assign zero2 = (m1_mag == 64'd0) && (m1_z == '0);

  localparam int SB3_W = 26;
  logic             c2_vld;
  taas_pkg::word_t  c2_x;
  taas_pkg::ang_t   c2_ang;
  logic [SB3_W-1:0] c2_sb;

  taas_cordic #(.STAGES(CORDIC_STAGES), .SB_W(SB3_W)) u_cordic_elev (
    .clk(clk), .rst_n(rst_n),
    .in_vld(m1_vld), .in_x(m1_mag), .in_y(m1_z), .in_ang('0),
    .in_sb({m1_sb[24:0], zero2}),
    .out_vld(c2_vld), .out_x(c2_x), .out_ang(c2_ang), .out_sb(c2_sb)
  );

  taas_pkg::word_t  c2_xm;
  taas_pkg::ang_t   base_c;
  assign c2_xm = c2_sb[0] ? '0 : c2_x;
  assign base_c = c2_sb[0] ? '0 : c2_ang;

  localparam int SB4_W = 25 + taas_pkg::ANG_W;
  logic             m2_vld;
  logic [63:0]      m2_mag;
  logic [SB4_W-1:0] m2_sb;

  taas_mag_scale #(.SB_W(SB4_W)) u_scale_elev (
    .clk(clk), .rst_n(rst_n),
    .in_vld(c2_vld), .in_x(c2_xm), .in_sb({c2_sb[25:1], base_c}),
    .out_vld(m2_vld), .out_mag(m2_mag), .out_sb(m2_sb)
  );

  // drag compensation and clamp
  logic               f1_vld_r;
  logic [55:0]        f1_prod_r;
  taas_pkg::ang_t     f1_base_r;
  logic signed [24:0] f1_yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= m2_vld;
    end
    f1_prod_r <= 56'(m2_mag[63:taas_pkg::GUARD_BITS]) * 56'(drag_gain_r);
    f1_base_r <= m2_sb[taas_pkg::ANG_W-1:0];
    f1_yaw_r <= m2_sb[SB4_W-1:taas_pkg::ANG_W];
  end

  logic signed [41:0] pitch_sum, lim_s;
  logic signed [41:0] pitch_c;

  always_comb begin
    pitch_sum = 42'(f1_base_r) + 42'($signed({2'b00, f1_prod_r[55:16]}));
    lim_s = 42'($signed({1'b0, pitch_limit_r}));
    pitch_c = pitch_sum;
    if (pitch_c > lim_s) pitch_c = lim_s;
    if (pitch_c < -lim_s) pitch_c = -lim_s;
  end

  logic               out_valid_r;
  logic signed [24:0] yaw_r;
  logic signed [23:0] pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f1_vld_r;
    end
    yaw_r <= f1_yaw_r;
    pitch_r <= pitch_c[23:0];
  end

  assign out_valid = out_valid_r;
  assign out_yaw_deg = yaw_r;
  assign out_pitch_deg = pitch_r;

  a_pitch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed({1'b0, $past(pitch_limit_r)}) >= 25'(out_pitch_deg))
      && (-$signed({1'b0, $past(pitch_limit_r)}) <= 25'(out_pitch_deg)))
    else $error("pitch outside limit");

  a_yaw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_deg <= 25'sd11796480) && (out_yaw_deg >= -25'sd11796480))
    else $error("yaw outside range");

  a_final_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    m2_vld |=> ##1 out_valid)
    else $error("result lost in final stages");

endmodule
